// File: rtl/core/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types and constants of the ray/triangle intersection core.
// ----------------------------------------------------------------------------
package rti_pkg;

    localparam int COORD_BITS    = 20;
    localparam int FRAC_BITS     = 10;
    localparam int OUT_FRAC_BITS = 16;
    localparam int PACK_BITS     = 3 * COORD_BITS;
    localparam int DET_THR_BITS  = 40;
    localparam int DIST_THR_BITS = 16;
    localparam int DIST_BITS     = 32;
    localparam int BARY_BITS     = OUT_FRAC_BITS + 1;
    localparam int INT_BITS      = DIST_BITS - 1 - OUT_FRAC_BITS;
    localparam int DIV_STEPS     = DIST_BITS - 1;
    localparam int ADET_BITS     = 63;
    localparam int NUM_BITS      = 64;
    localparam int DIV_W         = ADET_BITS + DIV_STEPS + 1;
    localparam int Q_DEPTH       = 16;
    localparam int Q_IDX_BITS    = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS    = $clog2(Q_DEPTH + 1);
    localparam int CFG_IDX_BITS  = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_VERTEX_A = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EDGE_AB  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EDGE_AC  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DET_THR  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIST_THR = 3'd4;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] origin_x;
        logic signed [COORD_BITS-1:0] origin_y;
        logic signed [COORD_BITS-1:0] origin_z;
        logic signed [COORD_BITS-1:0] dir_x;
        logic signed [COORD_BITS-1:0] dir_y;
        logic signed [COORD_BITS-1:0] dir_z;
    } t_rti_in;

    typedef struct packed {
        logic                        hit;
        logic signed [DIST_BITS-1:0] hit_distance;
        logic [BARY_BITS-1:0]        bary_u;
        logic [BARY_BITS-1:0]        bary_v;
    } t_rti_out;

    typedef struct packed {
        logic [PACK_BITS-1:0]     vertex_a;
        logic [PACK_BITS-1:0]     edge_ab;
        logic [PACK_BITS-1:0]     edge_ac;
        logic [DET_THR_BITS-1:0]  det_thr;
        logic [DIST_THR_BITS-1:0] dist_thr;
    } t_rti_cfg;

    typedef struct packed {
        logic                 ok;
        logic                 sat;
        logic [ADET_BITS-1:0] adet;
        logic [NUM_BITS-1:0]  unum;
        logic [NUM_BITS-1:0]  vnum;
        logic [NUM_BITS-1:0]  tnum;
    } t_rti_cls;

    typedef struct packed {
        logic                 ok;
        logic                 sat;
        logic [ADET_BITS-1:0] adet;
        logic [DIV_W-1:0]     rt;
        logic [DIV_W-1:0]     ru;
        logic [DIV_W-1:0]     rv;
        logic [DIV_STEPS-1:0] qt;
        logic [BARY_BITS-1:0] qu;
        logic [BARY_BITS-1:0] qv;
    } t_rti_div;

endpackage

// File: rtl/core/rti_front.sv
// ----------------------------------------------------------------------------
// rti_front
// Ray intake: cross and dot products, determinant and bound classification.
// ----------------------------------------------------------------------------
module rti_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rti_pkg::t_rti_in  i_ray,
    output logic              o_full,
    input  rti_pkg::t_rti_cfg i_cfg,
    input  logic              i_deq,
    output logic              o_enq,
    output rti_pkg::t_rti_cls o_cls
);
    localparam int CB  = rti_pkg::COORD_BITS;
    localparam int AB  = rti_pkg::ADET_BITS;
    localparam int NB  = rti_pkg::NUM_BITS;
    localparam int QC  = rti_pkg::Q_CNT_BITS;
    localparam int IB  = rti_pkg::INT_BITS;
    localparam int SW  = NB + IB;
    localparam int NSTG = 7;

    logic signed [CB-1:0] w_a  [3];
    logic signed [CB-1:0] w_ab [3];
    logic signed [CB-1:0] w_ac [3];
    logic signed [CB-1:0] w_o  [3];

    logic [NSTG-1:0] r_v;
    logic [QC-1:0]   r_cnt;
    logic [QC-1:0]   n_cnt;
    logic            w_acc;

    logic signed [CB-1:0]   r0_d  [3];
    logic signed [CB:0]     r0_t  [3];
    logic signed [2*CB-1:0] r1_pp [6];
    logic signed [2*CB:0]   r1_qp [6];
    logic signed [CB-1:0]   r1_d  [3];
    logic signed [CB:0]     r1_t  [3];
    logic signed [2*CB:0]   r2_p  [3];
    logic signed [2*CB+1:0] r2_q  [3];
    logic signed [CB-1:0]   r2_d  [3];
    logic signed [CB:0]     r2_t  [3];
    logic signed [3*CB:0]   r3_det [3];
    logic signed [3*CB+1:0] r3_un  [3];
    logic signed [3*CB+1:0] r3_vn  [3];
    logic signed [3*CB+1:0] r3_tn  [3];
    logic signed [NB-1:0]   r4_det;
    logic signed [NB-1:0]   r4_un;
    logic signed [NB-1:0]   r4_vn;
    logic signed [NB-1:0]   r4_tn;
    logic [AB-1:0]          r5_adet;
    logic signed [NB-1:0]   r5_un;
    logic signed [NB-1:0]   r5_vn;
    logic signed [NB-1:0]   r5_tn;
    rti_pkg::t_rti_cls      r6_cls;
    logic signed [NB-1:0]   w_adet_full;

    assign w_o[0] = i_ray.origin_x;
    assign w_o[1] = i_ray.origin_y;
    assign w_o[2] = i_ray.origin_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_a[i]  = $signed(i_cfg.vertex_a[CB*i +: CB]);
            w_ab[i] = $signed(i_cfg.edge_ab[CB*i +: CB]);
            w_ac[i] = $signed(i_cfg.edge_ac[CB*i +: CB]);
        end
    end

    assign w_acc  = i_push && !o_full;
    assign o_full = (r_cnt == QC'(rti_pkg::Q_DEPTH));
    assign n_cnt  = r_cnt + QC'(w_acc) - QC'(i_deq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= '0;
            r_cnt <= '0;
        end else begin
            r_v   <= {r_v[NSTG-2:0], w_acc};
            r_cnt <= n_cnt;
        end
    end

    assign w_adet_full = r4_det[NB-1] ? -r4_det : r4_det;

    always_ff @(posedge i_clk) begin
        r0_d[0] <= i_ray.dir_x;
        r0_d[1] <= i_ray.dir_y;
        r0_d[2] <= i_ray.dir_z;
        for (int i = 0; i < 3; i++) begin
            r0_t[i] <= (CB+1)'(w_o[i]) - (CB+1)'(w_a[i]);
        end

        r1_pp[0] <= r0_d[1] * w_ac[2];
        r1_pp[1] <= r0_d[2] * w_ac[1];
        r1_pp[2] <= r0_d[2] * w_ac[0];
        r1_pp[3] <= r0_d[0] * w_ac[2];
        r1_pp[4] <= r0_d[0] * w_ac[1];
        r1_pp[5] <= r0_d[1] * w_ac[0];
        r1_qp[0] <= r0_t[1] * w_ab[2];
        r1_qp[1] <= r0_t[2] * w_ab[1];
        r1_qp[2] <= r0_t[2] * w_ab[0];
        r1_qp[3] <= r0_t[0] * w_ab[2];
        r1_qp[4] <= r0_t[0] * w_ab[1];
        r1_qp[5] <= r0_t[1] * w_ab[0];
        r1_d <= r0_d;
        r1_t <= r0_t;

        for (int i = 0; i < 3; i++) begin
            r2_p[i] <= (2*CB+1)'(r1_pp[2*i]) - (2*CB+1)'(r1_pp[2*i+1]);
            r2_q[i] <= (2*CB+2)'(r1_qp[2*i]) - (2*CB+2)'(r1_qp[2*i+1]);
        end
        r2_d <= r1_d;
        r2_t <= r1_t;

        for (int i = 0; i < 3; i++) begin
            r3_det[i] <= w_ab[i] * r2_p[i];
            r3_un[i]  <= r2_t[i] * r2_p[i];
            r3_vn[i]  <= r2_d[i] * r2_q[i];
            r3_tn[i]  <= w_ac[i] * r2_q[i];
        end

        r4_det <= NB'(r3_det[0]) + NB'(r3_det[1]) + NB'(r3_det[2]);
        r4_un  <= NB'(r3_un[0]) + NB'(r3_un[1]) + NB'(r3_un[2]);
        r4_vn  <= NB'(r3_vn[0]) + NB'(r3_vn[1]) + NB'(r3_vn[2]);
        r4_tn  <= NB'(r3_tn[0]) + NB'(r3_tn[1]) + NB'(r3_tn[2]);

        r5_adet <= w_adet_full[AB-1:0];
        r5_un   <= r4_det[NB-1] ? -r4_un : r4_un;
        r5_vn   <= r4_det[NB-1] ? -r4_vn : r4_vn;
        r5_tn   <= r4_det[NB-1] ? -r4_tn : r4_tn;

        r6_cls.ok <= (r5_adet != '0)
                  && (r5_adet >= AB'(i_cfg.det_thr))
                  && !r5_un[NB-1]
                  && ($unsigned(r5_un) <= NB'(r5_adet))
                  && !r5_vn[NB-1]
                  && ((NB+1)'($unsigned(r5_un)) + (NB+1)'($unsigned(r5_vn))
                      <= (NB+1)'(r5_adet))
                  && !r5_tn[NB-1]
                  && (r5_tn != '0);
        r6_cls.sat  <= SW'($unsigned(r5_tn)) >= (SW'(r5_adet) << IB);
        r6_cls.adet <= r5_adet;
        r6_cls.unum <= $unsigned(r5_un);
        r6_cls.vnum <= $unsigned(r5_vn);
        r6_cls.tnum <= $unsigned(r5_tn);
    end

    assign o_enq = r_v[NSTG-1];
    assign o_cls = r6_cls;

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QC'(rti_pkg::Q_DEPTH))
        else $error("front credit count exceeds queue depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |=> !r_v[0])
        else $error("item entered while full");

endmodule

// File: rtl/core/rti_queue.sv
// ----------------------------------------------------------------------------
// rti_queue
// Short queue of classified rays between the front and the divider back end.
// ----------------------------------------------------------------------------
module rti_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rti_pkg::t_rti_cls i_cls,
    input  logic              i_pop,
    output logic              o_valid,
    output rti_pkg::t_rti_cls o_cls
);
    localparam int QI = rti_pkg::Q_IDX_BITS;
    localparam int QC = rti_pkg::Q_CNT_BITS;

    rti_pkg::t_rti_cls r_mem [rti_pkg::Q_DEPTH];
    logic [QI-1:0] r_wp;
    logic [QI-1:0] r_rp;
    logic [QC-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QI'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QI'(1);
            end
            r_cnt <= r_cnt + QC'(i_push) - QC'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cls;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_cls   = r_mem[r_rp];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && r_cnt == QC'(rti_pkg::Q_DEPTH)))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_cnt == '0))
        else $error("queue underflow");

endmodule

// File: rtl/core/rti_back.sv
// ----------------------------------------------------------------------------
// rti_back
// Restoring divider pipeline for t, u and v, and the result register.
// ----------------------------------------------------------------------------
module rti_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  rti_pkg::t_rti_cls i_cls,
    output logic              o_deq,
    input  rti_pkg::t_rti_cfg i_cfg,
    output logic              o_empty,
    input  logic              i_pop,
    output rti_pkg::t_rti_out o_res
);
    localparam int NS  = rti_pkg::DIV_STEPS;
    localparam int DW  = rti_pkg::DIV_W;
    localparam int OF  = rti_pkg::OUT_FRAC_BITS;
    localparam int DB  = rti_pkg::DIST_BITS;
    localparam int BB  = rti_pkg::BARY_BITS;

    logic                 w_en;
    logic [NS-1:0]        r_bv;
    rti_pkg::t_rti_div    r_div [NS];
    rti_pkg::t_rti_div    w_init;
    logic                 r_ov;
    rti_pkg::t_rti_out    r_out;
    rti_pkg::t_rti_out    w_out;
    logic [DB-1:0]        w_tq;

    assign w_en  = !r_ov || i_pop;
    assign o_deq = w_en && i_valid;

    always_comb begin
        w_init      = '0;
        w_init.ok   = i_cls.ok;
        w_init.sat  = i_cls.sat;
        w_init.adet = i_cls.adet;
        w_init.rt   = DW'(i_cls.tnum) << OF;
        w_init.ru   = DW'(i_cls.unum) << OF;
        w_init.rv   = DW'(i_cls.vnum) << OF;
    end

    for (genvar k = 0; k < NS; k++) begin : g_stg
        localparam int B = NS - 1 - k;
        rti_pkg::t_rti_div s_in;
        rti_pkg::t_rti_div s_nx;
        logic [DW-1:0]     dsh;

        if (k == 0) begin : g_first
            assign s_in = w_init;
        end else begin : g_next
            assign s_in = r_div[k-1];
        end

        assign dsh = DW'(s_in.adet) << B;

        if (B <= OF) begin : g_tuv
            always_comb begin
                s_nx = s_in;
                if (s_in.rt >= dsh) begin
                    s_nx.rt    = s_in.rt - dsh;
                    s_nx.qt[B] = 1'b1;
                end
                if (s_in.ru >= dsh) begin
                    s_nx.ru    = s_in.ru - dsh;
                    s_nx.qu[B] = 1'b1;
                end
                if (s_in.rv >= dsh) begin
                    s_nx.rv    = s_in.rv - dsh;
                    s_nx.qv[B] = 1'b1;
                end
            end
        end else begin : g_t
            always_comb begin
                s_nx = s_in;
                if (s_in.rt >= dsh) begin
                    s_nx.rt    = s_in.rt - dsh;
                    s_nx.qt[B] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_div[k] <= s_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_bv <= {r_bv[NS-2:0], i_valid};
            r_ov <= r_bv[NS-1];
        end
    end

    always_comb begin
        w_tq  = r_div[NS-1].sat ? {1'b0, {(DB-1){1'b1}}} : {1'b0, r_div[NS-1].qt};
        w_out = '0;
        if (r_div[NS-1].ok && (w_tq > DB'(i_cfg.dist_thr))) begin
            w_out.hit          = 1'b1;
            w_out.hit_distance = $signed(w_tq);
            w_out.bary_u       = r_div[NS-1].qu;
            w_out.bary_v       = r_div[NS-1].qv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= w_out;
        end
    end

    assign o_empty = !r_ov;
    assign o_res   = r_out;

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !r_out.hit |-> r_out.hit_distance == '0 && r_out.bary_u == '0
                               && r_out.bary_v == '0)
        else $error("miss result not cleared");

    a_bary_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_out.hit |-> (BB+1)'(r_out.bary_u) + (BB+1)'(r_out.bary_v)
                              <= (BB+1)'(1) << OF)
        else $error("barycentric sum exceeds one");

endmodule

// File: rtl/core/ray_triangle_intersect_core.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect_core
// Moller-Trumbore ray/triangle test against one configured triangle.
// ----------------------------------------------------------------------------
// One ray enters per cycle while o_full is low; each ray gives one result word,
// in order. A ray passes 7 front stages of products, sums and classification
// (the first registers the ray at the push edge), one queue slot, 31 restoring
// divider stages that produce one quotient bit of t per stage, and of u and v
// in the last 17 of them, and the result register. The sixteen-entry queue
// between the classifier and the divider lets the input keep flowing while the
// output stalls, until sixteen rays wait in the front and the queue. Write the
// triangle and the thresholds only while no ray is in flight.
module ray_triangle_intersect_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_push,
    input  rti_pkg::t_rti_in                       i_ray,
    output logic                                   o_full,
    output logic                                   o_empty,
    input  logic                                   i_pop,
    output rti_pkg::t_rti_out                      o_res,
    input  logic                                   i_cfg_wr_en,
    input  logic [rti_pkg::CFG_IDX_BITS-1:0]       i_cfg_addr,
    input  logic [rti_pkg::PACK_BITS-1:0]          i_cfg_wdata
);
    rti_pkg::t_rti_cfg r_cfg;
    rti_pkg::t_rti_cls w_fr_cls;
    rti_pkg::t_rti_cls w_q_cls;
    logic              w_enq;
    logic              w_deq;
    logic              w_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vertex_a <= '0;
            r_cfg.edge_ab  <= '0;
            r_cfg.edge_ac  <= '0;
            r_cfg.det_thr  <= rti_pkg::DET_THR_BITS'(1);
            r_cfg.dist_thr <= rti_pkg::DIST_THR_BITS'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                rti_pkg::CFG_VERTEX_A: begin
                    r_cfg.vertex_a <= i_cfg_wdata;
                end
                rti_pkg::CFG_EDGE_AB: begin
                    r_cfg.edge_ab <= i_cfg_wdata;
                end
                rti_pkg::CFG_EDGE_AC: begin
                    r_cfg.edge_ac <= i_cfg_wdata;
                end
                rti_pkg::CFG_DET_THR: begin
                    r_cfg.det_thr <= i_cfg_wdata[rti_pkg::DET_THR_BITS-1:0];
                end
                rti_pkg::CFG_DIST_THR: begin
                    r_cfg.dist_thr <= i_cfg_wdata[rti_pkg::DIST_THR_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    rti_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_ray   (i_ray),
        .o_full  (o_full),
        .i_cfg   (r_cfg),
        .i_deq   (w_deq),
        .o_enq   (w_enq),
        .o_cls   (w_fr_cls)
    );

    rti_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_enq),
        .i_cls   (w_fr_cls),
        .i_pop   (w_deq),
        .o_valid (w_q_valid),
        .o_cls   (w_q_cls)
    );

    rti_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_cls   (w_q_cls),
        .o_deq   (w_deq),
        .i_cfg   (r_cfg),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_res   (o_res)
    );

endmodule

// File: test/ray_triangle_intersect_core_tb.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect_core_tb
// Streams rays against several configured triangles and thresholds, predicts
// each result word with exact 64-bit arithmetic and checks it field by field.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_core_tb;
    import rti_pkg::*;

    localparam int LATENCY = 45;
    localparam longint CYCLE_LIMIT = 400000;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 3'd7;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_push = 1'b0;
    t_rti_in                 i_ray = '0;
    logic                    o_full;
    logic                    o_empty;
    logic                    i_pop = 1'b0;
    t_rti_out                o_res;
    logic                    i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_addr = '0;
    logic [PACK_BITS-1:0]    i_cfg_wdata = '0;

    t_rti_cfg tri_cfg;
    t_rti_out hit_queue[$];
    int       fail_count = 0;
    longint   cycle_count = 0;

    ray_triangle_intersect_core DUT (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic longint sx(logic [COORD_BITS-1:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint unsigned bary_bits(longint unsigned r, longint unsigned d);
        longint unsigned q;
        q = 0;
        for (int i = 0; i < OUT_FRAC_BITS; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 1;
            end
        end
        return q;
    endfunction

    function automatic longint unsigned unit_ratio(longint unsigned n, longint unsigned d);
        if (n >= d) return longint'(1) << OUT_FRAC_BITS;
        return bary_bits(n, d);
    endfunction

    function automatic t_rti_out predict_hit(t_rti_in ray);
        longint a[3], ab[3], ac[3], o[3], d[3], p[3], tv[3], q[3];
        longint det, unum, vnum, tnum;
        longint unsigned adet, ip, tq;
        t_rti_out r;
        r = '0;
        for (int i = 0; i < 3; i++) begin
            a[i]  = sx(tri_cfg.vertex_a[i*COORD_BITS +: COORD_BITS]);
            ab[i] = sx(tri_cfg.edge_ab[i*COORD_BITS +: COORD_BITS]);
            ac[i] = sx(tri_cfg.edge_ac[i*COORD_BITS +: COORD_BITS]);
        end
        o[0] = sx(ray.origin_x); o[1] = sx(ray.origin_y); o[2] = sx(ray.origin_z);
        d[0] = sx(ray.dir_x);    d[1] = sx(ray.dir_y);    d[2] = sx(ray.dir_z);
        p[0] = d[1]*ac[2] - d[2]*ac[1];
        p[1] = d[2]*ac[0] - d[0]*ac[2];
        p[2] = d[0]*ac[1] - d[1]*ac[0];
        det = ab[0]*p[0] + ab[1]*p[1] + ab[2]*p[2];
        if (det == 0) return r;
        adet = (det < 0) ? -det : det;
        if (adet < tri_cfg.det_thr) return r;
        for (int i = 0; i < 3; i++) tv[i] = o[i] - a[i];
        unum = tv[0]*p[0] + tv[1]*p[1] + tv[2]*p[2];
        q[0] = tv[1]*ab[2] - tv[2]*ab[1];
        q[1] = tv[2]*ab[0] - tv[0]*ab[2];
        q[2] = tv[0]*ab[1] - tv[1]*ab[0];
        vnum = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
        tnum = ac[0]*q[0] + ac[1]*q[1] + ac[2]*q[2];
        if (det < 0) begin
            unum = -unum; vnum = -vnum; tnum = -tnum;
        end
        if (unum < 0 || longint'(unum) > adet) return r;
        if (vnum < 0 || longint'(unum) + longint'(vnum) > adet) return r;
        if (tnum <= 0) return r;
        ip = longint'(tnum) / adet;
        if (ip >= (longint'(1) << (31 - OUT_FRAC_BITS))) tq = 64'h7FFF_FFFF;
        else tq = (ip << OUT_FRAC_BITS) | bary_bits(longint'(tnum) % adet, adet);
        if (tq <= tri_cfg.dist_thr) return r;
        r.hit = 1'b1;
        r.hit_distance = tq[31:0];
        r.bary_u = BARY_BITS'(unit_ratio(unum, adet));
        r.bary_v = BARY_BITS'(unit_ratio(vnum, adet));
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rti_out exp_w;
        if (i_rst_n && i_pop && !o_empty) begin
            if (hit_queue.size() == 0) begin
                $error("unexpected word %h", o_res);
                fail_count++;
            end else begin
                exp_w = hit_queue.pop_front();
                if (o_res.hit !== exp_w.hit) begin
                    $error("hit exp %0d got %0d", exp_w.hit, o_res.hit); fail_count++;
                end
                if (o_res.hit_distance !== exp_w.hit_distance) begin
                    $error("hit_distance exp %0d got %0d", exp_w.hit_distance,
                           o_res.hit_distance); fail_count++;
                end
                if (o_res.bary_u !== exp_w.bary_u) begin
                    $error("bary_u exp %0d got %0d", exp_w.bary_u, o_res.bary_u); fail_count++;
                end
                if (o_res.bary_v !== exp_w.bary_v) begin
                    $error("bary_v exp %0d got %0d", exp_w.bary_v, o_res.bary_v); fail_count++;
                end
            end
        end
    end

    // random pop stalls, with stretches of none
    initial begin
        int gap;
        forever begin
            @(negedge i_clk);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                i_pop <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_pop <= 1'b1;
            do @(posedge i_clk); while (o_empty || !i_rst_n);
        end
    end

    bit burst_mode = 0;

    task automatic send_ray(t_rti_in ray);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_ray  <= ray;
        i_push <= 1'b1;
        do @(posedge i_clk); while (o_full);
        hit_queue.push_back(predict_hit(ray));
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_push <= 1'b0;
        while (hit_queue.size() != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [PACK_BITS-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_VERTEX_A: tri_cfg.vertex_a = val;
            CFG_EDGE_AB:  tri_cfg.edge_ab  = val;
            CFG_EDGE_AC:  tri_cfg.edge_ac  = val;
            CFG_DET_THR:  tri_cfg.det_thr  = val[DET_THR_BITS-1:0];
            CFG_DIST_THR: tri_cfg.dist_thr = val[DIST_THR_BITS-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    function automatic logic [PACK_BITS-1:0] pack3(int x, int y, int z);
        return {z[COORD_BITS-1:0], y[COORD_BITS-1:0], x[COORD_BITS-1:0]};
    endfunction

    function automatic t_rti_in make_ray(int ox, int oy, int oz, int dx, int dy, int dz);
        t_rti_in r;
        r.origin_x = ox[COORD_BITS-1:0]; r.origin_y = oy[COORD_BITS-1:0];
        r.origin_z = oz[COORD_BITS-1:0];
        r.dir_x = dx[COORD_BITS-1:0]; r.dir_y = dy[COORD_BITS-1:0];
        r.dir_z = dz[COORD_BITS-1:0];
        return r;
    endfunction

    function automatic int rnd_coord(int span);
        return $urandom_range(0, 2*span) - span;
    endfunction

    // ray aimed through a random point of the triangle, with a small jitter
    function automatic t_rti_in aimed_ray(int span);
        int a[3], ab[3], ac[3], o[3], tgt[3];
        int fu, fv;
        fu = $urandom_range(0, 1024);
        fv = $urandom_range(0, 1024 - fu);
        for (int i = 0; i < 3; i++) begin
            a[i]  = int'(sx(tri_cfg.vertex_a[i*COORD_BITS +: COORD_BITS]));
            ab[i] = int'(sx(tri_cfg.edge_ab[i*COORD_BITS +: COORD_BITS]));
            ac[i] = int'(sx(tri_cfg.edge_ac[i*COORD_BITS +: COORD_BITS]));
            tgt[i] = a[i] + (ab[i]*fu)/1024 + (ac[i]*fv)/1024;
            o[i] = rnd_coord(span);
        end
        return make_ray(o[0], o[1], o[2],
                        tgt[0]-o[0] + rnd_coord(8), tgt[1]-o[1] + rnd_coord(8),
                        tgt[2]-o[2] + rnd_coord(8));
    endfunction

    task automatic test_defaults();
        send_ray(make_ray(0, 0, 0, 1024, 0, 0));
        send_ray('1);
        send_ray('0);
        drain();
    endtask

    task automatic test_directed();
        int k = 1024;
        write_reg(CFG_VERTEX_A, pack3(0, 0, 5*k));
        write_reg(CFG_EDGE_AB, pack3(4*k, 0, 0));
        write_reg(CFG_EDGE_AC, pack3(0, 4*k, 0));
        write_reg(CFG_DET_THR, PACK_BITS'(1));
        write_reg(CFG_DIST_THR, PACK_BITS'(1));
        write_reg(CFG_UNUSED, '1);
        send_ray(make_ray(k, k, 0, 0, 0, k));          // plain hit
        send_ray(make_ray(k, k, 10*k, 0, 0, k));       // behind origin
        send_ray(make_ray(k, k, 0, 0, 0, -k));         // pointing away, positive determinant
        send_ray(make_ray(k, k, 0, k, 0, 0));          // parallel
        send_ray(make_ray(-k, k, 0, 0, 0, k));         // u below zero
        send_ray(make_ray(k, -k, 0, 0, 0, k));         // v below zero
        send_ray(make_ray(3*k, 3*k, 0, 0, 0, k));      // u+v over one
        send_ray(make_ray(0, 0, 0, 0, 0, k));          // vertex A
        send_ray(make_ray(4*k, 0, 0, 0, 0, k));        // vertex B
        send_ray(make_ray(0, 4*k, 0, 0, 0, k));        // vertex C
        send_ray(make_ray(k, k, 5*k - 1, 0, 0, 1));    // tiny direction, unit distance
        send_ray(make_ray(k, k, -524288, 0, 0, 1));    // saturated distance
        send_ray(make_ray(524287, 524287, -524288, -524288, -524288, 524287));
        send_ray(make_ray(k, k, 5*k - 1, 0, 0, 524287)); // below distance threshold
        drain();
        write_reg(CFG_DET_THR, '0);
        send_ray(make_ray(k, k, 0, k, 0, 0));          // zero det, threshold zero
        send_ray(make_ray(k, k, 0, 0, 0, k));
        drain();
        write_reg(CFG_DET_THR, '1);
        send_ray(make_ray(k, k, 0, 0, 0, k));
        drain();
        write_reg(CFG_DET_THR, PACK_BITS'(1));
        write_reg(CFG_DIST_THR, PACK_BITS'(16'hFFFF));
        send_ray(make_ray(k, k, 0, 0, 0, k));
        send_ray(make_ray(k, k, -524288, 0, 0, 1));
        drain();
    endtask

    task automatic test_random(int n_items, int span);
        logic [127:0] rbits;
        logic [63:0]  thr;
        int ex[3], ey[3];
        for (int i = 0; i < 3; i++) begin
            ex[i] = rnd_coord(span);
            ey[i] = rnd_coord(span);
        end
        write_reg(CFG_VERTEX_A, pack3(rnd_coord(span), rnd_coord(span), rnd_coord(span)));
        write_reg(CFG_EDGE_AB, pack3(ex[0], ex[1], ex[2]));
        write_reg(CFG_EDGE_AC, pack3(ey[0], ey[1], ey[2]));
        thr = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'd1;
        write_reg(CFG_DET_THR, thr[PACK_BITS-1:0]);
        write_reg(CFG_DIST_THR,
                  PACK_BITS'($urandom_range(0, 1) ? $urandom_range(0, 65535) : 0));
        for (int n = 0; n < n_items; n++) begin
            burst_mode = (n % 100) < 30;
            if ($urandom_range(0, 9) < 7) send_ray(aimed_ray(span));
            else begin
                rbits = {$urandom, $urandom, $urandom, $urandom};
                send_ray(rbits[$bits(t_rti_in)-1:0]);
            end
        end
        burst_mode = 0;
        drain();
    endtask

    initial begin
        tri_cfg = '0;
        tri_cfg.det_thr = DET_THR_BITS'(1);
        tri_cfg.dist_thr = DIST_THR_BITS'(1);
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_defaults();
        test_directed();
        test_random(300, 4096);
        test_random(300, 65536);
        test_random(250, 524287);
        test_random(150, 256);
        if (fail_count == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule

// File: sim.f
rtl/core/rti_pkg.sv
rtl/core/rti_front.sv
rtl/core/rti_queue.sv
rtl/core/rti_back.sv
rtl/core/ray_triangle_intersect_core.sv
test/ray_triangle_intersect_core_tb.sv
